// ===== rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg
// Shared types and constants of the k-way run merger: the input and result
// item layouts and the fixed field widths.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_RUNS = 8;
  localparam int DATA_W   = 32;
  localparam int RUN_W    = $clog2(MAX_RUNS);
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RUNS_RESET = 4'd2;

  typedef struct packed {
    logic [RUN_W-1:0]         run_index;
    logic signed [DATA_W-1:0] element;
    logic                     final_of_run;
    logic                     run_is_empty;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] merged_value;
    logic [RUN_W-1:0]         refill_run;
    logic                     merge_done;
  } out_item_t;

endpackage

// ===== rtl/kwm_front.sv =====
// ----------------------------------------------------------------------------
// kwm_front
// Input side: takes items, drops those aimed at an inactive run, and holds
// the rest in a two-entry command queue for the merge engine.
// ----------------------------------------------------------------------------
module kwm_front #(
  parameter int CNT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  kwm_pkg::in_item_t in_item,
  input  logic [CNT_W-1:0]  run_count,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output kwm_pkg::in_item_t cmd
);
  import kwm_pkg::*;

  in_item_t    q_mem [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        accept;
  logic        in_range;
  logic        do_wr;
  logic        do_rd;

  assign full      = (count == 2'd2);
  assign accept    = push && !full;
  assign in_range  = (int'(in_item.run_index) < int'(run_count));
  assign do_wr     = accept && in_range;
  assign cmd_valid = (count != 2'd0);
  assign do_rd     = cmd_valid && cmd_ready;
  assign cmd       = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/kwm_back.sv =====
// ----------------------------------------------------------------------------
// kwm_back
// Merge engine: applies one command to the run heads, then scans the active
// runs one per cycle to find the smallest head, emitted if no open run lacks one.
// ----------------------------------------------------------------------------
module kwm_back #(
  parameter int CNT_W    = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [CNT_W-1:0]   run_count,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  kwm_pkg::in_item_t  cmd,
  output logic               res_valid,
  input  logic               res_ready,
  output kwm_pkg::out_item_t res
);
  import kwm_pkg::*;

  localparam int IDX_W = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_LAST   = 2'd2;
  localparam logic [1:0] ST_DECIDE = 2'd3;

  logic [DATA_W-1:0]   head_mem [MAX_RUNS];
  logic [DATA_W-1:0]   rd_data;
  logic [MAX_RUNS-1:0] head_valid;
  logic [MAX_RUNS-1:0] run_fin;
  logic [MAX_RUNS-1:0] head_fin;

  logic [1:0]          state;
  logic [IDX_W-1:0]    idx;
  logic                s1_vld;
  logic [IDX_W-1:0]    s1_idx;
  logic                any_head;
  logic                all_ready;
  logic [IDX_W-1:0]    best;
  logic [DATA_W-1:0]   best_val;

  logic [IDX_W-1:0]    cmd_run;
  logic                take_cmd;
  logic                apply_cmd;
  logic                wr_en;
  logic                last_idx;
  logic                emit;
  logic                done;

  assign cmd_ready = (state == ST_IDLE);
  assign take_cmd  = cmd_valid && cmd_ready;
  assign cmd_run   = IDX_W'(cmd.run_index);
  assign apply_cmd = take_cmd && !head_valid[cmd_run] && !run_fin[cmd_run];
  assign wr_en     = apply_cmd && !cmd.run_is_empty;
  assign last_idx  = (int'(idx) == int'(run_count) - 1);

  assign res_valid = (state == ST_DECIDE) && all_ready && any_head;
  assign emit      = res_valid && res_ready;

  // The merge is over once every active run is finished with no head left,
  // counting the effect of the head being emitted now.
  always_comb begin
    logic vnext;
    logic fnext;
    done = 1'b1;
    for (int i = 0; i < MAX_RUNS; i++) begin
      vnext = head_valid[i] && (i != int'(best));
      fnext = run_fin[i] || ((i == int'(best)) && head_fin[i]);
      if ((i < int'(run_count)) && (!fnext || vnext)) begin
        done = 1'b0;
      end
    end
  end

  assign res.merged_value = best_val;
  assign res.refill_run   = RUN_W'(best);
  assign res.merge_done   = done;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_mem[cmd_run] <= cmd.element;
    end
    rd_data <= head_mem[idx];
  end

  always_ff @(posedge clk) begin
    s1_idx <= idx;
    if (s1_vld) begin
      if (head_valid[s1_idx]) begin
        if (!any_head || ($signed(rd_data) < $signed(best_val))) begin
          best     <= s1_idx;
          best_val <= rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      s1_vld     <= 1'b0;
      any_head   <= 1'b0;
      all_ready  <= 1'b1;
      head_valid <= '0;
      run_fin    <= '0;
      head_fin   <= '0;
    end else begin
      s1_vld <= (state == ST_SCAN);
      if (s1_vld) begin
        if (head_valid[s1_idx]) begin
          any_head <= 1'b1;
        end else if (!run_fin[s1_idx]) begin
          all_ready <= 1'b0;
        end
      end
      case (state)
        ST_IDLE: begin
          if (apply_cmd) begin
            if (cmd.run_is_empty) begin
              run_fin[cmd_run] <= 1'b1;
            end else begin
              head_valid[cmd_run] <= 1'b1;
              head_fin[cmd_run]   <= cmd.final_of_run;
            end
            idx       <= '0;
            any_head  <= 1'b0;
            all_ready <= 1'b1;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (last_idx) begin
            state <= ST_LAST;
          end else begin
            idx <= idx + IDX_W'(1);
          end
        end
        ST_LAST: begin
          state <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (!all_ready) begin
            state <= ST_IDLE;
          end else if (!any_head) begin
            // Every active run was empty: start over with no result.
            head_valid <= '0;
            run_fin    <= '0;
            head_fin   <= '0;
            state      <= ST_IDLE;
          end else if (emit) begin
            if (done) begin
              head_valid <= '0;
              run_fin    <= '0;
              head_fin   <= '0;
              state      <= ST_IDLE;
            end else begin
              head_valid[best] <= 1'b0;
              if (head_fin[best]) begin
                // The run just ran out, so the next head can be chosen now.
                run_fin[best]  <= 1'b1;
                head_fin[best] <= 1'b0;
                idx            <= '0;
                any_head       <= 1'b0;
                all_ready      <= 1'b1;
                state          <= ST_SCAN;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/kwm_out_q.sv =====
// ----------------------------------------------------------------------------
// kwm_out_q
// Two-entry result queue between the merge engine and the output port.
// ----------------------------------------------------------------------------
module kwm_out_q (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  output logic               res_ready,
  input  kwm_pkg::out_item_t res,
  output logic               empty,
  input  logic               pop,
  output kwm_pkg::out_item_t out_item
);
  import kwm_pkg::*;

  out_item_t  q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign res_ready = (count != 2'd2);
  assign empty     = (count == 2'd0);
  assign do_wr     = res_valid && res_ready;
  assign do_rd     = pop && !empty;
  assign out_item  = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/k_way_run_merger_unit.sv =====
// ----------------------------------------------------------------------------
// k_way_run_merger_unit
// Merges up to MAX_RUNS ascending runs of signed values into one ascending
// stream, naming the run to refill after each emitted element.
// ----------------------------------------------------------------------------
// Usage:
// Write active_runs on the cfg channel (cfg_ready is always high) while the
// block is idle. Push one element of a run per transaction on the input
// queue port; pop merged results from the result queue port.
// A transaction for a run outside the active set is dropped at the input.
// A taken element waits in the input queue until the engine is idle and
// applies it, then the engine scans the n active heads (one head per cycle
// through the head memory read port), settles the minimum in ST_LAST and
// hands it over in ST_DECIDE, where a full result queue holds it. Each
// further result caused by the same transaction takes another scan. The
// engine takes no new transaction until it is back in ST_IDLE; a transaction
// that is ignored leaves it idle.
// Reset empties both queues, clears all run state and sets active_runs to 2.
// When the receiver stops popping, the two-entry result queue fills, the
// engine holds its pending result, the two-entry input queue fills and
// full rises.
// ----------------------------------------------------------------------------
module k_way_run_merger_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  kwm_pkg::in_item_t          in_item,
  output logic                       empty,
  input  logic                       pop,
  output kwm_pkg::out_item_t         out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [kwm_pkg::CFG_W-1:0]  cfg_data
);
  import kwm_pkg::*;

  localparam int CNT_W = $clog2(MAX_RUNS + 1);

  logic [CFG_W-1:0] active_runs;
  logic [CNT_W-1:0] run_count;
  logic             cmd_valid;
  logic             cmd_ready;
  in_item_t         cmd;
  logic             res_valid;
  logic             res_ready;
  out_item_t        res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_runs <= ACTIVE_RUNS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_runs <= cfg_data;
    end
  end

  // A count of zero acts as one run; a count above the storage is clamped.
  always_comb begin
    if (active_runs == '0) begin
      run_count = CNT_W'(1);
    end else if (int'(active_runs) > MAX_RUNS) begin
      run_count = CNT_W'(MAX_RUNS);
    end else begin
      run_count = CNT_W'(active_runs);
    end
  end

  kwm_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .run_count (run_count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  kwm_back #(
    .CNT_W    (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .run_count (run_count),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  kwm_out_q u_out_q (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item)
  );

endmodule
